>>> hw/rtl/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types, codes and helpers for the wildcard glob matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

  // Request modes on the input channel
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_TEXT   = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  // Wildcard characters
  localparam logic [7:0] SYM_STAR  = 8'h2A;
  localparam logic [7:0] SYM_QUEST = 8'h3F;

  // ASCII lower-case range and fold offset
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // Input request
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] symbol;
  } in_req_t;

  // Result
  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_res_t;

  // Classified command between front and back
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] symbol;
    logic       is_star;
    logic       is_quest;
  } cmd_t;

  // Queue handshake driven by the back end
  typedef struct packed {
    logic cmd_pop;
    logic res_push;
  } back_ctl_t;

  // Fold a-z to A-Z when case is ignored
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && (c >= LOWER_A) && (c <= LOWER_Z)) begin
      r = c - CASE_DIFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wgm_fifo.sv
// ----------------------------------------------------------------------------
// wgm_fifo
// Small synchronous FIFO with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // Pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wgm_front.sv
// ----------------------------------------------------------------------------
// wgm_front
// Accepts requests, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_front #(
  parameter int QDEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire wgm_pkg::in_req_t in_req,
  output logic                  in_full,
  input  wire logic             cmd_pop,
  output wgm_pkg::cmd_t         cmd,
  output logic                  cmd_empty
);

  wgm_pkg::cmd_t                  cls;
  logic [$bits(wgm_pkg::cmd_t)-1:0] cmd_bits;

  // Classify: flag wildcards once so the back end only tests bits
  always_comb begin
    cls.op       = in_req.mode;
    cls.symbol   = in_req.symbol;
    cls.is_star  = (in_req.symbol == wgm_pkg::SYM_STAR);
    cls.is_quest = (in_req.symbol == wgm_pkg::SYM_QUEST);
  end

  wgm_fifo #(
    .WIDTH ($bits(wgm_pkg::cmd_t)),
    .DEPTH (QDEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd = wgm_pkg::cmd_t'(cmd_bits);

endmodule

`default_nettype wire

>>> hw/rtl/wgm_back.sv
// ----------------------------------------------------------------------------
// wgm_back
// Executes commands: pattern lanes, active-position vector with star
// closure, pattern length and overflow tracking, case-fold register.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_back #(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  input  wire wgm_pkg::cmd_t cmd,
  input  wire logic          cmd_empty,
  input  wire logic          res_full,
  output wgm_pkg::back_ctl_t ctl,
  output wgm_pkg::out_res_t  res
);

  localparam int N   = PATTERN_MAX;
  localparam int LW  = $clog2(N + 1);
  localparam int LVL = $clog2(N + 1);

  // Pattern lanes (payload, no reset)
  logic [7:0] pat_r   [N];
  logic [N-1:0] star_r;
  logic [N-1:0] quest_r;

  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic [N:0]    active_r, active_nxt;
  logic          ic_r;

  logic          cmd_go;
  logic [7:0]    tc;
  logic [N-1:0]  lane_valid;
  logic [N-1:0]  wr_lane;
  logic [N-1:0]  mask_cur;
  logic [N-1:0]  mask_app;
  logic [N-1:0]  mask_sel;
  logic [N:0]    step_stay;
  logic [N:0]    step_adv;
  logic [N:0]    base;
  logic [N:0]    closed;
  logic          len_room;

  // Prefix network for star closure
  logic [N:0] g_lv [LVL+1];
  logic [N:0] p_lv [LVL+1];

  assign cmd_go   = !cmd_empty && ((cmd.op != wgm_pkg::MODE_END) || !res_full);
  assign tc       = wgm_pkg::fold_char(cmd.symbol, ic_r);
  assign len_room = (len_r < LW'(N));

  // Per-lane compare and next-position step
  for (genvar i = 0; i < N; i++) begin : g_lane
    logic hit;
    logic eq;
    assign lane_valid[i] = (LW'(i) < len_r);
    assign wr_lane[i]    = (len_r == LW'(i));
    assign mask_cur[i]   = star_r[i] & lane_valid[i];
    assign mask_app[i]   = mask_cur[i] | (wr_lane[i] & cmd.is_star);
    assign hit           = active_r[i] & lane_valid[i];
    assign eq            = (wgm_pkg::fold_char(pat_r[i], ic_r) == tc);
    assign step_stay[i]  = hit & star_r[i];
    assign step_adv[i+1] = hit & !star_r[i] & (quest_r[i] | eq);

    always_ff @(posedge clk) begin
      if (cmd_go && (cmd.op == wgm_pkg::MODE_APPEND) && wr_lane[i]) begin
        pat_r[i]   <= cmd.symbol;
        star_r[i]  <= cmd.is_star;
        quest_r[i] <= cmd.is_quest;
      end
    end
  end
  assign step_stay[N] = 1'b0;
  assign step_adv[0]  = 1'b0;

  // Closure: a[j] |= star[j-1] & a[j-1], as a log-depth prefix
  assign g_lv[0] = base;
  assign p_lv[0] = {mask_sel, 1'b0};
  for (genvar lv = 0; lv < LVL; lv++) begin : g_lvl
    for (genvar j = 0; j <= N; j++) begin : g_pos
      if (j >= (1 << lv)) begin : g_comb
        assign g_lv[lv+1][j] = g_lv[lv][j] | (p_lv[lv][j] & g_lv[lv][j-(1<<lv)]);
        assign p_lv[lv+1][j] = p_lv[lv][j] & p_lv[lv][j-(1<<lv)];
      end else begin : g_copy
        assign g_lv[lv+1][j] = g_lv[lv][j];
        assign p_lv[lv+1][j] = p_lv[lv][j];
      end
    end
  end
  assign closed = g_lv[LVL];

  // Command decode and next state
  always_comb begin
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    base       = (N + 1)'(1);
    mask_sel   = mask_cur;
    active_nxt = active_r;
    unique case (cmd.op)
      wgm_pkg::MODE_CLEAR: begin
        len_nxt  = '0;
        ovf_nxt  = 1'b0;
        mask_sel = '0;
      end
      wgm_pkg::MODE_APPEND: begin
        if (len_room) begin
          len_nxt  = len_r + LW'(1);
          mask_sel = mask_app;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      wgm_pkg::MODE_TEXT: begin
        base = step_stay | step_adv;
      end
      wgm_pkg::MODE_END: begin
        base = (N + 1)'(1);
      end
      default: begin
        base = (N + 1)'(1);
      end
    endcase
    if (cmd_go) begin
      active_nxt = closed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      ovf_r    <= 1'b0;
      active_r <= (N + 1)'(1);
    end else if (cmd_go) begin
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      active_r <= active_nxt;
    end
  end

  // Case-fold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r <= 1'b0;
    end else if (cfg_we) begin
      ic_r <= cfg_wdata;
    end
  end

  // Result for end of text
  assign res.matched          = active_r[len_r];
  assign res.pattern_overflow = ovf_r;
  assign ctl.cmd_pop          = cmd_go;
  assign ctl.res_push         = cmd_go && (cmd.op == wgm_pkg::MODE_END);

endmodule

`default_nettype wire

>>> hw/rtl/wildcard_glob_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Streams text against a stored glob pattern ('*' and '?'), one result per
// end of text.
// ----------------------------------------------------------------------------
// Requests enter through a push/full port and results leave through a
// pop/empty port. The block takes one request every clock cycle while
// in_full is low: a two-entry command queue feeds the execute stage, which
// updates the whole active-position vector (all pattern lanes compared in
// parallel, star closure through a log-depth prefix network) per command.
// An end-of-text result passes through the command queue and a two-entry
// result queue before it can be popped; only a full result queue stalls the
// execute stage, and only on end-of-text requests. Up to PATTERN_MAX pattern
// characters are kept; further appends are dropped and flagged until the
// next clear. cfg_wdata selects ASCII case-insensitive compare. The user
// writes it only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire wgm_pkg::in_req_t  in_req,
  output logic                   in_full,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output wgm_pkg::out_res_t      out_res,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata
);

  localparam int QDEPTH = 2;

  wgm_pkg::cmd_t      cmd;
  logic               cmd_empty;
  wgm_pkg::back_ctl_t ctl;
  wgm_pkg::out_res_t  res;
  logic               res_full;
  logic [$bits(wgm_pkg::out_res_t)-1:0] res_bits;

  // Front: accept and classify
  wgm_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_req    (in_req),
    .in_full   (in_full),
    .cmd_pop   (ctl.cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  // Back: execute against the pattern
  wgm_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .res_full  (res_full),
    .ctl       (ctl),
    .res       (res)
  );

  // Result queue
  wgm_fifo #(
    .WIDTH ($bits(wgm_pkg::out_res_t)),
    .DEPTH (QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ctl.res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_bits),
    .empty (out_empty)
  );

  assign out_res = wgm_pkg::out_res_t'(res_bits);

  // Back end never pushes a result into a full queue
  a_no_res_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.res_push && res_full))
    else $error("result pushed into full queue");

  // Back end only pops an existing command
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // An accepted request is visible to the back end next cycle
  a_req_reaches_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !cmd_empty)
    else $error("accepted request lost before back end");

endmodule

`default_nettype wire
